FILE: rtl/lzwd_pkg.sv
// shared types, constants and helper functions of the lzw variable width decoder
// used by the core and the packer, no dependencies
`default_nettype none
package lzwd_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int DICT_AW      = $clog2(DICT_ENTRIES);
  localparam int CODE_W       = DICT_AW + 1;
  localparam int MAX_STRING   = 512;
  localparam int LEN_W        = $clog2(MAX_STRING) + 1;
  localparam int STACK_AW     = $clog2(MAX_STRING);
  localparam int WIDTH_W      = $clog2(CODE_W + 1);
  localparam int ALPHA_W      = 9;
  localparam int ALPHA_MAX    = 256;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_BIT  = 1'b1;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_LONG    = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        tail;
    logic [LEN_W-1:0]  len;
  } dict_word_t;

  localparam int DICT_W = $bits(dict_word_t);

  typedef struct packed {
    logic clr;
    logic push;
  } pack_ctl_t;

  function automatic logic [WIDTH_W-1:0] bit_len(input logic [CODE_W-1:0] n);
    logic [WIDTH_W-1:0] b;
    b = WIDTH_W'(1);
    for (int i = 1; i < CODE_W; i++) begin
      if (n[i]) b = WIDTH_W'(i + 1);
    end
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (l == '0) r = LEN_W'(1);
    if (l > LEN_W'(MAX_STRING)) r = LEN_W'(MAX_STRING);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lzw_variable_width_decoder_core.sv
// lzw decoder with variable code width, top level with the decode sequencer
// depends on lzwd_pkg, lzwd_ram and lzwd_packer
//
// usage: write alphabet_size over apb (address 0), then load the alphabet
// with s_tuser = 0 beats (symbol_index in s_tdata[7:0], symbol in [15:8]).
// code bits follow as s_tuser = 1 beats, bit in s_tdata[16], msb first,
// s_tlast on the final bit of a stream. each complete code gives one or more
// m_ beats of up to eight bytes; m_tlast marks the last beat of a code and
// m_tuser carries the error code (error beats have a byte count of zero).
// a complete code reads the previous length and checks the code (only the
// check when no entry can be added), walks the prefix chain (one byte fewer
// for a code equal to the entry count), adds the entry, reads the bytes back
// and packs them, then presents each output beat. the single read port of
// each ram paces the walk and the read-back. s_tready is low while a code
// is decoded; a stalled receiver holds the sequencer in its output state.
// reset sets alphabet_size to 256 and restarts the stream; dictionary and
// stack contents are left unset.
`default_nettype none
module lzw_variable_width_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // symbol_index[7:0], symbol[15:8], code_bit[16]
  input  logic        s_tuser,  // func
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // out_bytes[63:0], byte_count[67:64]
  output logic [1:0]  m_tuser,  // error
  output logic        m_tlast
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_PLEN_RD = 11'b00000000010,
    S_PLEN    = 11'b00000000100,
    S_CHECK   = 11'b00000001000,
    S_WALK_RD = 11'b00000010000,
    S_WALK    = 11'b00000100000,
    S_KWK     = 11'b00001000000,
    S_ADD     = 11'b00010000000,
    S_EMIT_RD = 11'b00100000000,
    S_EMIT    = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

  localparam int CW = lzwd_pkg::CODE_W;
  localparam int LW = lzwd_pkg::LEN_W;
  localparam int AW = lzwd_pkg::DICT_AW;
  localparam int SW = lzwd_pkg::STACK_AW;

  state_t                         state;
  logic [lzwd_pkg::ALPHA_W-1:0]   alpha;
  logic [CW-1:0]                  entry_count;
  logic [CW-1:0]                  acc;
  logic [lzwd_pkg::WIDTH_W-1:0]   bcnt;
  logic [CW-1:0]                  prev;
  logic                           first_pend;
  logic [CW-1:0]                  code;
  logic                           eos_pend;
  logic [LW-1:0]                  plen;
  logic [CW-1:0]                  node;
  logic                           kwk;
  logic                           first_rd;
  logic [LW-1:0]                  cnt;
  logic [LW-1:0]                  tot_len;
  logic [7:0]                     first_byte;
  logic [LW-1:0]                  epos;
  logic [1:0]                     err;
  logic                           last;

  logic                           cfg_wr;
  logic [lzwd_pkg::ALPHA_W-1:0]   cfg_val;
  logic                           s_acc;
  logic [CW-1:0]                  acc_next;
  logic [lzwd_pkg::WIDTH_W-1:0]   bcnt_next;
  logic                           can_add;
  logic                           restart;

  logic                           d_we;
  logic [AW-1:0]                  d_waddr;
  lzwd_pkg::dict_word_t           d_wdata;
  logic [AW-1:0]                  d_raddr;
  logic [lzwd_pkg::DICT_W-1:0]    d_rdata;
  lzwd_pkg::dict_word_t           dword;
  logic [LW-1:0]                  rd_len;
  logic [LW-1:0]                  widx;

  logic                           st_we;
  logic [SW-1:0]                  st_waddr;
  logic [7:0]                     st_wdata;
  logic [7:0]                     st_rdata;

  lzwd_pkg::pack_ctl_t            pk_ctl;
  logic [63:0]                    pk_word;
  logic [3:0]                     pk_count;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {{(32-lzwd_pkg::ALPHA_W){1'b0}}, alpha} : '0;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_comb begin
    cfg_val = pwdata[lzwd_pkg::ALPHA_W-1:0];
    if (cfg_val == '0) cfg_val = lzwd_pkg::ALPHA_W'(1);
    if (cfg_val > lzwd_pkg::ALPHA_W'(lzwd_pkg::ALPHA_MAX)) begin
      cfg_val = lzwd_pkg::ALPHA_W'(lzwd_pkg::ALPHA_MAX);
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign acc_next  = {acc[CW-2:0], s_tdata[16]};
  assign bcnt_next = bcnt + 1'b1;
  assign can_add   = !first_pend && (entry_count < CW'(lzwd_pkg::DICT_ENTRIES));
  assign restart   = (state == S_OUT) && m_tready && last && eos_pend;

  assign dword  = lzwd_pkg::dict_word_t'(d_rdata);
  assign rd_len = lzwd_pkg::clamp_len(dword.len);
  assign widx   = first_rd ? (rd_len - LW'(1)) : (cnt - LW'(1));

  // dictionary ports
  always_comb begin
    d_we    = 1'b0;
    d_waddr = entry_count[AW-1:0];
    d_wdata = '{prefix: prev, tail: first_byte, len: plen + LW'(1)};
    if (s_acc && s_tuser == lzwd_pkg::FUNC_LOAD
        && {1'b0, s_tdata[7:0]} < alpha) begin
      d_we    = 1'b1;
      d_waddr = {{(AW-8){1'b0}}, s_tdata[7:0]};
      d_wdata = '{prefix: '0, tail: s_tdata[15:8], len: LW'(1)};
    end
    if (state == S_ADD && can_add) d_we = 1'b1;
    if (state == S_PLEN_RD) d_raddr = prev[AW-1:0];
    else                    d_raddr = node[CW-1] ? '0 : node[AW-1:0];
  end

  // output stack ports
  always_comb begin
    st_we    = (state == S_WALK) || (state == S_KWK);
    st_waddr = (state == S_KWK) ? plen[SW-1:0] : widx[SW-1:0];
    st_wdata = (state == S_KWK) ? first_byte : dword.tail;
  end

  assign pk_ctl.clr  = (state == S_IDLE) || ((state == S_OUT) && m_tready && !last);
  assign pk_ctl.push = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      alpha       <= lzwd_pkg::ALPHA_W'(lzwd_pkg::ALPHA_MAX);
      entry_count <= CW'(lzwd_pkg::ALPHA_MAX);
      acc         <= '0;
      bcnt        <= '0;
      prev        <= '0;
      first_pend  <= 1'b1;
      eos_pend    <= 1'b0;
      err         <= lzwd_pkg::ERR_NONE;
      last        <= 1'b0;
    end else if (cfg_wr) begin
      alpha       <= cfg_val;
      entry_count <= {{(CW-lzwd_pkg::ALPHA_W){1'b0}}, cfg_val};
      acc         <= '0;
      bcnt        <= '0;
      prev        <= '0;
      first_pend  <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc && s_tuser == lzwd_pkg::FUNC_BIT) begin
            eos_pend <= s_tlast;
            if (bcnt_next >= lzwd_pkg::bit_len(entry_count)) begin
              code  <= acc_next;
              acc   <= '0;
              bcnt  <= '0;
              err   <= lzwd_pkg::ERR_NONE;
              state <= can_add ? S_PLEN_RD : S_CHECK;
            end else if (s_tlast) begin
              err   <= lzwd_pkg::ERR_TRUNC;
              last  <= 1'b1;
              state <= S_OUT;
            end else begin
              acc  <= acc_next;
              bcnt <= bcnt_next;
            end
          end
        end
        S_PLEN_RD: state <= S_PLEN;
        S_PLEN: begin
          plen  <= rd_len;
          state <= S_CHECK;
        end
        S_CHECK: begin
          first_rd <= 1'b1;
          if (code < entry_count) begin
            node <= code;
            kwk  <= 1'b0;
            if (can_add && plen == LW'(lzwd_pkg::MAX_STRING)) begin
              err   <= lzwd_pkg::ERR_LONG;
              last  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_WALK_RD;
            end
          end else if (code == entry_count && can_add) begin
            node <= prev;
            kwk  <= 1'b1;
            if (plen == LW'(lzwd_pkg::MAX_STRING)) begin
              err   <= lzwd_pkg::ERR_LONG;
              last  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_WALK_RD;
            end
          end else begin
            err   <= lzwd_pkg::ERR_INVALID;
            last  <= 1'b1;
            state <= S_OUT;
          end
        end
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          if (first_rd) tot_len <= rd_len + LW'(kwk);
          first_rd <= 1'b0;
          cnt      <= widx;
          node     <= dword.prefix;
          if (widx == '0) begin
            first_byte <= dword.tail;
            state      <= kwk ? S_KWK : S_ADD;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_KWK: state <= S_ADD;
        S_ADD: begin
          if (can_add) entry_count <= entry_count + CW'(1);
          prev       <= code;
          first_pend <= 1'b0;
          epos       <= '0;
          state      <= S_EMIT_RD;
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          epos <= epos + LW'(1);
          if (epos + LW'(1) == tot_len) begin
            last  <= 1'b1;
            state <= S_OUT;
          end else if (pk_count == 4'd7) begin
            last  <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (last) begin
              state    <= S_IDLE;
              eos_pend <= 1'b0;
              if (restart) begin
                entry_count <= {{(CW-lzwd_pkg::ALPHA_W){1'b0}}, alpha};
                acc         <= '0;
                bcnt        <= '0;
                prev        <= '0;
                first_pend  <= 1'b1;
              end
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lzwd_ram #(.WIDTH(lzwd_pkg::DICT_W), .DEPTH(lzwd_pkg::DICT_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::MAX_STRING)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (epos[SW-1:0]),
    .rdata (st_rdata)
  );

  lzwd_packer u_packer (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pk_ctl),
    .byte_in (st_rdata),
    .word    (pk_word),
    .count   (pk_count)
  );

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {4'b0, pk_count, pk_word};
  assign m_tuser  = err;
  assign m_tlast  = last;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result beat is pending");

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(lzwd_pkg::DICT_ENTRIES))
    else $error("dictionary entry count beyond capacity");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != lzwd_pkg::ERR_NONE) |-> (m_tlast && m_tdata[67:64] == 4'd0))
    else $error("error beat carries data or is not last");

  a_data_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == lzwd_pkg::ERR_NONE)
      |-> (m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8))
    else $error("data beat byte count out of range");

  a_full_mid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[67:64] == 4'd8))
    else $error("non-final beat not full");

endmodule
`default_nettype wire

FILE: rtl/lzwd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/lzwd_packer.sv
// packs decoded bytes one at a time into an eight byte output word
// depends on lzwd_pkg
`default_nettype none
module lzwd_packer (
  input  logic               clk,
  input  logic               rst,
  input  lzwd_pkg::pack_ctl_t ctl,
  input  logic [7:0]         byte_in,
  output logic [63:0]        word,
  output logic [3:0]         count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.clr) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      word[count[2:0]*8 +: 8] <= byte_in;
      count                   <= count + 4'd1;
    end
  end

endmodule
`default_nettype wire
